/* src/ndpm_pkg.sv */
// ----------------------------------------------------------------------------
// ndpm_pkg
// Shared types, constants and the twiddle table builder for the NTT-domain
// pair multiplier.
// ----------------------------------------------------------------------------
package ndpm_pkg;

	localparam int MODULUS     = 3329;
	localparam int ROOT        = 17;
	localparam int N_COEFF_DEF = 256;
	localparam int COEF_W      = 12;
	localparam int IDX_W       = 7;
	localparam int N_PAIRS_MAX = 1 << IDX_W;

	typedef struct packed {
		logic [IDX_W-1:0]  pair_index;
		logic [COEF_W-1:0] f_even;
		logic [COEF_W-1:0] f_odd;
		logic [COEF_W-1:0] g_even;
		logic [COEF_W-1:0] g_odd;
	} in_beat_t;

	typedef struct packed {
		logic [COEF_W-1:0] h_even;
		logic [COEF_W-1:0] h_odd;
	} out_beat_t;

	typedef logic [COEF_W-1:0] gamma_tbl_t [0:N_PAIRS_MAX-1];

	// Builds gamma(i) = ROOT^(2*bitrev7(i)+1) mod MODULUS for every pair index.
	// Only ever evaluated at elaboration to fill a constant table.
	function automatic gamma_tbl_t build_gamma_tbl();
		gamma_tbl_t tbl;
		int         br;
		int         expo;
		int         acc;
		for (int i = 0; i < N_PAIRS_MAX; i++) begin
			br = 0;
			for (int k = 0; k < IDX_W; k++) begin
				br = (br << 1) | ((i >> k) & 1);
			end
			expo = 2 * br + 1;
			acc  = 1;
			for (int j = 0; j < expo; j++) begin
				acc = (acc * ROOT) % MODULUS;
			end
			tbl[i] = COEF_W'(acc);
		end
		return tbl;
	endfunction

endpackage

/* src/ndpm_mod_reduce.sv */
// ----------------------------------------------------------------------------
// ndpm_mod_reduce
// Three-stage Barrett reduction of a W-bit unsigned value modulo 3329.
// ----------------------------------------------------------------------------
module ndpm_mod_reduce
	import ndpm_pkg::*;
#(
	parameter int W = 24
) (
	input  logic              clk,
	input  logic [2:0]        en,
	input  logic [W-1:0]      x,
	output logic [COEF_W-1:0] r
);

	// The quotient estimate fits in W-11 bits since MODULUS exceeds 2^11.
	localparam int MW = W - 11;
	localparam int PW = W + MW;
	localparam int RW = COEF_W + 1;
	localparam logic [MW-1:0] BARRETT_M = MW'((64'd1 << W) / MODULUS);
	localparam logic [W-1:0]  MOD_W     = W'(MODULUS);
	localparam logic [RW-1:0] MOD_R     = RW'(MODULUS);

	logic [W-1:0]  x_s1;
	logic [PW-1:0] prod_s1;
	logic [MW-1:0] quot;
	logic [W-1:0]  diff;
	logic [RW-1:0] rem_s2;
	logic [COEF_W-1:0] res_s3;

	// The estimate is the true quotient or one below it, so the remainder
	// stays under twice the modulus and fits in RW bits.
	assign quot = prod_s1[PW-1:W];
	assign diff = x_s1 - W'(quot) * MOD_W;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s1    <= x;
			prod_s1 <= PW'(x) * PW'(BARRETT_M);
		end
		if (en[1]) begin
			rem_s2 <= diff[RW-1:0];
		end
		if (en[2]) begin
			res_s3 <= (rem_s2 >= MOD_R) ? COEF_W'(rem_s2 - MOD_R) : COEF_W'(rem_s2);
		end
	end

	assign r = res_s3;

endmodule

/* src/ntt_domain_pair_multiply.sv */
// ----------------------------------------------------------------------------
// ntt_domain_pair_multiply
// Base-case multiplication of two NTT-domain polynomials modulo 3329, one
// coefficient pair per beat.
// ----------------------------------------------------------------------------
// Usage:
// The operand channel carries one coefficient pair of f, the matching pair of
// g and the pair index in each beat. The product channel returns one beat per
// operand beat, in order, with h_even = f0*g0 + f1*g1*gamma and
// h_odd = f0*g1 + f1*g0, both fully reduced mod 3329. Gamma comes from a
// constant table of 17^(2*bitrev7(i)+1) mod 3329, built at elaboration; the
// index is wrapped to N_COEFF/2 entries.
// Throughput is one beat per cycle while the receiver does not stall. The
// stages are table lookup, four partial products, three-stage Barrett
// reduction of f1*g1, the gamma multiply, the even sum and a second
// three-stage reduction of both outputs. Each stage has its own
// valid bit and loads whenever it is empty or the stage after it moves, so
// bubbles are squeezed out and a stalled receiver holds only the stages that
// are actually full. The last stage is the output register, and the operand
// channel stalls only when every stage is occupied and the receiver stalls.
// Reset clears all valid bits; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module ntt_domain_pair_multiply
	import ndpm_pkg::*;
#(
	parameter int N_COEFF = N_COEFF_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      operand_valid,
	output logic      operand_stall,
	input  in_beat_t  operand,
	output logic      product_valid,
	input  logic      product_stall,
	output out_beat_t product
);

	localparam int NSTG = 10;
	localparam int PRW  = 2 * COEF_W;
	localparam int SW   = PRW + 1;
	localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(N_COEFF / 2 - 1);
	localparam gamma_tbl_t GAMMA_TBL = build_gamma_tbl();

	// Per-stage valid bits and load enables. A stage loads when it is empty
	// or when its contents move on into the next stage in the same cycle.
	logic [NSTG:1]   vld_q;
	logic [NSTG+1:1] en;
	logic [NSTG:0]   vld_in;

	always_comb begin
		en[NSTG+1] = !product_stall;
		for (int k = NSTG; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign vld_in = {vld_q, operand_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NSTG; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_in[k-1];
				end
			end
		end
	end

	assign operand_stall = !en[1];
	assign product_valid = vld_q[NSTG];

	// Stage 1: capture the operands and look up gamma for the wrapped index.
	logic [COEF_W-1:0] f0_s1, f1_s1, g0_s1, g1_s1, gamma_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			f0_s1    <= operand.f_even;
			f1_s1    <= operand.f_odd;
			g0_s1    <= operand.g_even;
			g1_s1    <= operand.g_odd;
			gamma_s1 <= GAMMA_TBL[operand.pair_index & IDX_MASK];
		end
	end

	// Stage 2: the four partial products.
	logic [PRW-1:0]    p00_s2, p11_s2, p01_s2, p10_s2;
	logic [COEF_W-1:0] gamma_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			p00_s2   <= PRW'(f0_s1) * PRW'(g0_s1);
			p11_s2   <= PRW'(f1_s1) * PRW'(g1_s1);
			p01_s2   <= PRW'(f0_s1) * PRW'(g1_s1);
			p10_s2   <= PRW'(f1_s1) * PRW'(g0_s1);
			gamma_s2 <= gamma_s1;
		end
	end

	// Stages 3 to 5: reduce f1*g1 so that the gamma multiply stays 12 by 12.
	// The other terms ride alongside; the odd sum is formed on entry.
	logic [COEF_W-1:0] cross_red;
	logic [PRW-1:0]    p00_s3, p00_s4, p00_s5;
	logic [SW-1:0]     odd_s3, odd_s4, odd_s5;
	logic [COEF_W-1:0] gamma_s3, gamma_s4, gamma_s5;

	ndpm_mod_reduce #(
		.W (PRW)
	) u_cross_red (
		.clk (clk),
		.en  (en[5:3]),
		.x   (p11_s2),
		.r   (cross_red)
	);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			p00_s3   <= p00_s2;
			odd_s3   <= SW'(p01_s2) + SW'(p10_s2);
			gamma_s3 <= gamma_s2;
		end
		if (en[4]) begin
			p00_s4   <= p00_s3;
			odd_s4   <= odd_s3;
			gamma_s4 <= gamma_s3;
		end
		if (en[5]) begin
			p00_s5   <= p00_s4;
			odd_s5   <= odd_s4;
			gamma_s5 <= gamma_s4;
		end
	end

	// Stage 6: multiply the reduced cross term by gamma.
	logic [PRW-1:0] cross_s6, p00_s6;
	logic [SW-1:0]  odd_s6;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			cross_s6 <= PRW'(cross_red) * PRW'(gamma_s5);
			p00_s6   <= p00_s5;
			odd_s6   <= odd_s5;
		end
	end

	// Stage 7: the even sum; both sums are below 2^25.
	logic [SW-1:0] even_s7, odd_s7;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			even_s7 <= SW'(p00_s6) + SW'(cross_s6);
			odd_s7  <= odd_s6;
		end
	end

	// Stages 8 to 10: final reduction of both outputs. The last reduction
	// stage is the output register.
	logic [COEF_W-1:0] h_even_red, h_odd_red;

	ndpm_mod_reduce #(
		.W (SW)
	) u_even_red (
		.clk (clk),
		.en  (en[10:8]),
		.x   (even_s7),
		.r   (h_even_red)
	);

	ndpm_mod_reduce #(
		.W (SW)
	) u_odd_red (
		.clk (clk),
		.en  (en[10:8]),
		.x   (odd_s7),
		.r   (h_odd_red)
	);

	assign product.h_even = h_even_red;
	assign product.h_odd  = h_odd_red;

endmodule
